/* src/rbr_pkg.sv */
// ----------------------------------------------------------------------------
// rbr_pkg
// Shared constants, command codes and beat types of the RBSP bit reader.
// ----------------------------------------------------------------------------
package rbr_pkg;

  localparam int BUFFER_BYTES  = 4096;
  localparam int POS_W         = 13;                // holds 0 .. BUFFER_BYTES
  localparam int STREAM_W      = 13;
  localparam int WORD_COUNT    = BUFFER_BYTES / 4;  // 32-bit words in the store
  localparam int WIDX_W        = POS_W - 2;
  localparam int BANK_DEPTH    = WORD_COUNT / 2;    // even and odd word banks
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int MAX_READ_BITS = 32;
  localparam int COUNT_W       = 6;
  localparam int VALUE_W       = 32;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         load_value;
    logic [COUNT_W-1:0] bit_count;
    logic               advance;
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0] bits_value;
    logic               more_data;
  } result_t;

  // Store read setup, driven in the cycle a command is taken
  typedef struct packed {
    logic             ld_sel;
    logic [POS_W-1:0] load_pos;
    logic [POS_W-1:0] read_pos;
  } fetch_t;

  // Byte merge for the write-back half of a load
  typedef struct packed {
    logic       en;
    logic [1:0] lane;
    logic [7:0] data;
  } merge_t;

endpackage

/* src/rbr_ram.sv */
// ----------------------------------------------------------------------------
// rbr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/rbr_store.sv */
// ----------------------------------------------------------------------------
// rbr_store
// Byte store as two interleaved banks of 32-bit words. A read fetches the two
// words that hold a five-byte window; a load reads its word and writes it back
// with one byte lane replaced.
// ----------------------------------------------------------------------------
module rbr_store (
  input  logic                   clk,
  input  rbr_pkg::fetch_t        fetch,
  input  rbr_pkg::merge_t        merge,
  output logic [31:0]            first_word,
  output logic [31:0]            second_word
);
  import rbr_pkg::*;

  logic [WIDX_W-1:0]  rd_idx;
  logic [WIDX_W-1:0]  rd_idx_inc;
  logic [WIDX_W-1:0]  idx_even;
  logic [WIDX_W-1:0]  idx_odd;
  logic [WIDX_W-1:0]  ld_idx;
  logic [BANK_AW-1:0] addr_even;
  logic [BANK_AW-1:0] addr_odd;
  logic [31:0]        even_data;
  logic [31:0]        odd_data;
  logic [31:0]        even_word;
  logic [31:0]        odd_word;
  logic [31:0]        merged;
  logic               we_even;
  logic               we_odd;

  // side information captured with the read data
  logic               even_first;
  logic               even_ok;
  logic               odd_ok;
  logic               ld_bank;
  logic [BANK_AW-1:0] ld_addr;

  always_comb begin
    rd_idx     = fetch.read_pos[POS_W-1:2];
    rd_idx_inc = rd_idx + WIDX_W'(1);
    idx_even   = rd_idx[0] ? rd_idx_inc : rd_idx;
    idx_odd    = rd_idx[0] ? rd_idx : rd_idx_inc;
    ld_idx     = fetch.load_pos[POS_W-1:2];
    if (fetch.ld_sel) begin
      addr_even = ld_idx[BANK_AW:1];
      addr_odd  = ld_idx[BANK_AW:1];
    end else begin
      addr_even = idx_even[BANK_AW:1];
      addr_odd  = idx_odd[BANK_AW:1];
    end
  end

  always_ff @(posedge clk) begin
    even_first <= ~rd_idx[0];
    even_ok    <= (idx_even < WIDX_W'(WORD_COUNT));
    odd_ok     <= (idx_odd < WIDX_W'(WORD_COUNT));
    ld_bank    <= ld_idx[0];
    ld_addr    <= ld_idx[BANK_AW:1];
  end

  // words past the end of the buffer read as zero
  assign even_word   = even_ok ? even_data : '0;
  assign odd_word    = odd_ok ? odd_data : '0;
  assign first_word  = even_first ? even_word : odd_word;
  assign second_word = even_first ? odd_word : even_word;

  // lane 0 is the first byte of the word, held in the top bits
  always_comb begin
    merged = ld_bank ? odd_data : even_data;
    for (int k = 0; k < 4; k++) begin
      if (merge.lane == 2'(k)) begin
        merged[31-8*k -: 8] = merge.data;
      end
    end
  end

  assign we_even = merge.en & ~ld_bank;
  assign we_odd  = merge.en & ld_bank;

  rbr_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (ld_addr),
    .wdata (merged),
    .raddr (addr_even),
    .rdata (even_data)
  );

  rbr_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (ld_addr),
    .wdata (merged),
    .raddr (addr_odd),
    .rdata (odd_data)
  );

endmodule

/* src/rbr_extract.sv */
// ----------------------------------------------------------------------------
// rbr_extract
// Field extractor: aligns the 64-bit word pair to the read position and
// returns the requested number of bits right-aligned.
// ----------------------------------------------------------------------------
module rbr_extract (
  input  logic [31:0]                  first_word,
  input  logic [31:0]                  second_word,
  input  logic [1:0]                   byte_off,
  input  logic [2:0]                   bit_pos,
  input  logic [rbr_pkg::COUNT_W-1:0]  count,
  output logic [rbr_pkg::VALUE_W-1:0]  value
);
  import rbr_pkg::*;

  logic [63:0]        aligned;
  logic [COUNT_W-1:0] rshift;

  always_comb begin
    aligned = {first_word, second_word} << {byte_off, bit_pos};
    rshift  = COUNT_W'(MAX_READ_BITS) - count;
    if (count == '0) begin
      value = '0;
    end else begin
      value = aligned[63:32] >> rshift[4:0];
    end
  end

endmodule

/* src/rbsp_bit_reader.sv */
// ----------------------------------------------------------------------------
// rbsp_bit_reader
// MSB-first bit reader over a loadable byte store.
// ----------------------------------------------------------------------------
// Timing: a command is taken while IDLE and moves the block to EXEC, where
//   busy is high; result_valid and the result are registered from EXEC.
// Commands: a new command is not taken while busy; the store's registered read
//   comes first, then extraction or the load write-back in EXEC.
// Reset: positions clear, stream_length becomes 1; the store is not cleared
//   and holds undefined data until loaded.
module rbsp_bit_reader (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  rbr_pkg::request_t        request,
  output logic                     result_valid,
  output rbr_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [rbr_pkg::STREAM_W-1:0] cfg_data
);
  import rbr_pkg::*;

  typedef enum logic {IDLE, EXEC} state_t;

  state_t           state;
  state_t           state_next;
  request_t         req_q;
  logic [POS_W-1:0] read_byte_pos;
  logic [POS_W-1:0] read_byte_pos_next;
  logic [2:0]       read_bit_pos;
  logic [2:0]       read_bit_pos_next;
  logic [POS_W-1:0] load_pos;
  logic [POS_W-1:0] load_pos_next;
  logic [STREAM_W-1:0] stream_length;
  result_t          result_next;

  fetch_t             fetch;
  merge_t             merge;
  logic [31:0]        first_word;
  logic [31:0]        second_word;
  logic [COUNT_W-1:0] count;
  logic [VALUE_W-1:0] value;
  logic [5:0]         total;
  logic [POS_W:0]     byte_sum;
  logic               accept;
  logic               has_room;

  assign busy      = (state == EXEC);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign has_room  = (load_pos < POS_W'(BUFFER_BYTES));

  assign fetch.ld_sel   = (request.command == CMD_LOAD);
  assign fetch.load_pos = load_pos;
  assign fetch.read_pos = read_byte_pos;

  assign merge.en   = busy && (req_q.command == CMD_LOAD) && has_room;
  assign merge.lane = load_pos[1:0];
  assign merge.data = req_q.load_value;

  assign count = (req_q.bit_count > COUNT_W'(MAX_READ_BITS)) ?
                 COUNT_W'(MAX_READ_BITS) : req_q.bit_count;

  rbr_store u_store (
    .clk         (clk),
    .fetch       (fetch),
    .merge       (merge),
    .first_word  (first_word),
    .second_word (second_word)
  );

  rbr_extract u_extract (
    .first_word  (first_word),
    .second_word (second_word),
    .byte_off    (read_byte_pos[1:0]),
    .bit_pos     (read_bit_pos),
    .count       (count),
    .value       (value)
  );

  always_comb begin
    state_next         = state;
    read_byte_pos_next = read_byte_pos;
    read_bit_pos_next  = read_bit_pos;
    load_pos_next      = load_pos;
    total              = {3'b000, read_bit_pos} + count;
    byte_sum           = {1'b0, read_byte_pos} + (POS_W+1)'(total[5:3]);
    result_next.bits_value = '0;

    case (state)
      IDLE: begin
        if (accept) begin
          state_next = EXEC;
        end
      end
      EXEC: begin
        state_next = IDLE;
        case (req_q.command)
          CMD_LOAD: begin
            if (has_room) begin
              load_pos_next = load_pos + POS_W'(1);
            end
          end
          CMD_RESTART: begin
            read_byte_pos_next = '0;
            read_bit_pos_next  = '0;
            load_pos_next      = '0;
          end
          CMD_READ: begin
            result_next.bits_value = value;
            if (req_q.advance && (count != '0)) begin
              // park at the end of the buffer on overrun
              if (byte_sum >= (POS_W+1)'(BUFFER_BYTES)) begin
                read_byte_pos_next = POS_W'(BUFFER_BYTES);
                read_bit_pos_next  = '0;
              end else begin
                read_byte_pos_next = byte_sum[POS_W-1:0];
                read_bit_pos_next  = total[2:0];
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = IDLE;
      end
    endcase

    result_next.more_data =
      (({1'b0, read_byte_pos_next} + (POS_W+1)'(1)) < {1'b0, stream_length});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      read_byte_pos <= '0;
      read_bit_pos  <= '0;
      load_pos      <= '0;
      stream_length <= STREAM_W'(1);
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      read_byte_pos <= read_byte_pos_next;
      read_bit_pos  <= read_bit_pos_next;
      load_pos      <= load_pos_next;
      result_valid  <= busy;
      if (cfg_valid && cfg_ready) begin
        stream_length <= cfg_data;
      end
    end
    if (accept) begin
      req_q <= request;
    end
    if (busy) begin
      result <= result_next;
    end
  end

endmodule

/* src/rbr_checker.sv */
// ----------------------------------------------------------------------------
// rbr_checker
// Port-level checks of the RBSP bit reader command timing and results.
// ----------------------------------------------------------------------------
module rbr_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input rbr_pkg::request_t request,
  input logic              result_valid,
  input rbr_pkg::result_t  result
);
  import rbr_pkg::*;

  // a taken beat raises busy
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command was taken");

  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    busy |=> (result_valid && !busy))
    else $error("result did not follow the execute cycle");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat without a command in flight");

  // only reads carry a value
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ($past(request.command, 2) != CMD_READ))
      |-> (result.bits_value == '0))
    else $error("non-read command returned nonzero bits");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ($past(request.bit_count, 2) == '0))
      |-> (result.bits_value == '0))
    else $error("zero-bit read returned nonzero bits");

endmodule

bind rbsp_bit_reader rbr_checker u_rbr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .request      (request),
  .result_valid (result_valid),
  .result       (result)
);
